// ===== hdl/sddvp_pkg.sv =====
`timescale 1ns / 1ps
package sddvp_pkg;

   localparam int POSITION_BITS = 18;
   localparam int TGT_BITS      = 17;
   localparam int MV_BITS       = 14;
   localparam int Q8_BITS       = 9;
   localparam int OUT_BITS      = 15;
   localparam int FRAC_BITS     = 8;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam int CMP_BITS  = (POSITION_BITS > TGT_BITS) ? POSITION_BITS : TGT_BITS;
   localparam int DEC_BITS  = (POSITION_BITS + FRAC_BITS > TGT_BITS + Q8_BITS) ?
                              (POSITION_BITS + FRAC_BITS) : (TGT_BITS + Q8_BITS);
   localparam int DEN_BITS  = TGT_BITS + Q8_BITS;
   localparam int PROD_BITS = MV_BITS + TGT_BITS;
   localparam int QUOT_BITS = MV_BITS;
   localparam int LOW_SHIFT = QUOT_BITS - FRAC_BITS;
   localparam int CNT_BITS  = $clog2(QUOT_BITS);
   localparam int MUL_BITS  = MV_BITS + Q8_BITS;

   localparam logic [Q8_BITS-1:0]  Q8_ONE    = Q8_BITS'(256);
   localparam logic [CMP_BITS:0]   DONE_TOL  = (CMP_BITS + 1)'(5);
   localparam logic [MV_BITS-1:0]  OUT_MAX   = MV_BITS'(16383);

   localparam logic [TGT_BITS-1:0] RST_TARGET_DEGREES   = '0;
   localparam logic [MV_BITS-1:0]  RST_MAX_MILLIVOLTS   = MV_BITS'(10000);
   localparam logic [Q8_BITS-1:0]  RST_INNER_RATIO_Q8   = Q8_BITS'(256);
   localparam logic                RST_TURN_LEFT        = 1'b0;
   localparam logic                RST_MOVE_FORWARD     = 1'b1;
   localparam logic [MV_BITS-1:0]  RST_SLEW_STEP        = MV_BITS'(500);
   localparam logic [MV_BITS-1:0]  RST_FLOOR_MILLIVOLTS = MV_BITS'(2000);
   localparam logic [Q8_BITS-1:0]  RST_DECEL_START_Q8   = Q8_BITS'(179);

   typedef enum logic [2:0] {
      REG_TARGET_DEGREES   = 3'd0,
      REG_MAX_MILLIVOLTS   = 3'd1,
      REG_INNER_RATIO_Q8   = 3'd2,
      REG_TURN_LEFT        = 3'd3,
      REG_MOVE_FORWARD     = 3'd4,
      REG_SLEW_STEP        = 3'd5,
      REG_FLOOR_MILLIVOLTS = 3'd6,
      REG_DECEL_START_Q8   = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_RAMP,
      ST_MUL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [DEN_BITS-1:0]  rem_init;
      logic [QUOT_BITS-1:0] num_low;
      logic [DEN_BITS-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [QUOT_BITS-1:0] quot;
   } div_rsp_type;

endpackage

// ===== hdl/sddvp_req_if.sv =====
`timescale 1ns / 1ps
interface sddvp_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [sddvp_pkg::POSITION_BITS-1:0] left_position;
   logic signed [sddvp_pkg::POSITION_BITS-1:0] right_position;
   logic                                     restart;

   modport source (output valid, output left_position, output right_position,
                   output restart, input ready);
   modport sink (input valid, input left_position, input right_position,
                 input restart, output ready);
endinterface

// ===== hdl/sddvp_rsp_if.sv =====
`timescale 1ns / 1ps
interface sddvp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [sddvp_pkg::OUT_BITS-1:0] left_millivolts;
   logic signed [sddvp_pkg::OUT_BITS-1:0] right_millivolts;
   logic                                done_res;

   modport source (output valid, output left_millivolts, output right_millivolts,
                   output done_res, input ready);
   modport sink (input valid, input left_millivolts, input right_millivolts,
                 input done_res, output ready);
endinterface

// ===== hdl/sddvp_div.sv =====
`timescale 1ns / 1ps
module sddvp_div (
   input  logic                   clock,
   input  logic                   reset,
   input  sddvp_pkg::div_req_type div_req,
   output sddvp_pkg::div_rsp_type div_rsp
);
   import sddvp_pkg::*;

   logic [DEN_BITS-1:0]  rem_ff, rem_in;
   logic [DEN_BITS-1:0]  den_ff, den_in;
   logic [QUOT_BITS-1:0] num_ff, num_in;
   logic [QUOT_BITS-1:0] quot_ff, quot_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DEN_BITS:0]    trial;
   logic                 fits;

   // one quotient bit per cycle, numerator bits shift in from the top
   always_comb begin
      trial   = {rem_ff, num_ff[QUOT_BITS-1]};
      fits    = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.rem_init;
         den_in  = div_req.den;
         num_in  = div_req.num_low;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? DEN_BITS'(trial - {1'b0, den_ff}) : DEN_BITS'(trial);
         num_in  = {num_ff[QUOT_BITS-2:0], 1'b0};
         quot_in = {quot_ff[QUOT_BITS-2:0], fits};
         cnt_in  = CNT_BITS'(cnt_ff + CNT_BITS'(1));
         if (cnt_ff == CNT_BITS'(QUOT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < den_ff)
      else $error("partial remainder not below divisor");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divide done without a running divide");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> busy_ff)
      else $error("divide start did not begin iteration");

endmodule

// ===== hdl/slew_decel_drive_voltage_profile.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake       payload
// req_ch    in         valid / ready   left_position, right_position, restart
// rsp_ch    out        valid / ready   left_millivolts, right_millivolts, done_res
// csr_*     in         apb write/read  eight drive profile registers
//
// a request goes through prep, the divider when deceleration needs it (one quotient bit
// per cycle, 14 bits), ramp, mul and out; a finished move goes straight from prep to out
// the next request is accepted the cycle after its result is loaded, no earlier
// reset is synchronous and active high; it loads the register defaults, clears the
// ramp and done state and holds req_ch.ready low
// a stalled result holds in the output register while the next request is worked on
module slew_decel_drive_voltage_profile (
   input  logic                                  clock,
   input  logic                                  reset,
   sddvp_req_if.sink                             req_ch,
   sddvp_rsp_if.source                           rsp_ch,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [sddvp_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [sddvp_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [sddvp_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                  csr_pready
);
   import sddvp_pkg::*;

   // configuration registers
   logic [TGT_BITS-1:0] target_degrees_ff;
   logic [MV_BITS-1:0]  max_millivolts_ff;
   logic [Q8_BITS-1:0]  inner_ratio_q8_ff;
   logic                turn_left_ff;
   logic                move_forward_ff;
   logic [MV_BITS-1:0]  slew_step_ff;
   logic [MV_BITS-1:0]  floor_millivolts_ff;
   logic [Q8_BITS-1:0]  decel_start_q8_ff;

   logic          csr_write;
   csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_degrees_ff   <= RST_TARGET_DEGREES;
         max_millivolts_ff   <= RST_MAX_MILLIVOLTS;
         inner_ratio_q8_ff   <= RST_INNER_RATIO_Q8;
         turn_left_ff        <= RST_TURN_LEFT;
         move_forward_ff     <= RST_MOVE_FORWARD;
         slew_step_ff        <= RST_SLEW_STEP;
         floor_millivolts_ff <= RST_FLOOR_MILLIVOLTS;
         decel_start_q8_ff   <= RST_DECEL_START_Q8;
      end else if (csr_write) begin
         case (csr_index)
            REG_TARGET_DEGREES:   target_degrees_ff   <= csr_pwdata[TGT_BITS-1:0];
            REG_MAX_MILLIVOLTS:   max_millivolts_ff   <= csr_pwdata[MV_BITS-1:0];
            REG_INNER_RATIO_Q8:   inner_ratio_q8_ff   <= csr_pwdata[Q8_BITS-1:0];
            REG_TURN_LEFT:        turn_left_ff        <= csr_pwdata[0];
            REG_MOVE_FORWARD:     move_forward_ff     <= csr_pwdata[0];
            REG_SLEW_STEP:        slew_step_ff        <= csr_pwdata[MV_BITS-1:0];
            REG_FLOOR_MILLIVOLTS: floor_millivolts_ff <= csr_pwdata[MV_BITS-1:0];
            REG_DECEL_START_Q8:   decel_start_q8_ff   <= csr_pwdata[Q8_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_TARGET_DEGREES:   csr_prdata = CSR_DATA_BITS'(target_degrees_ff);
         REG_MAX_MILLIVOLTS:   csr_prdata = CSR_DATA_BITS'(max_millivolts_ff);
         REG_INNER_RATIO_Q8:   csr_prdata = CSR_DATA_BITS'(inner_ratio_q8_ff);
         REG_TURN_LEFT:        csr_prdata = CSR_DATA_BITS'(turn_left_ff);
         REG_MOVE_FORWARD:     csr_prdata = CSR_DATA_BITS'(move_forward_ff);
         REG_SLEW_STEP:        csr_prdata = CSR_DATA_BITS'(slew_step_ff);
         REG_FLOOR_MILLIVOLTS: csr_prdata = CSR_DATA_BITS'(floor_millivolts_ff);
         REG_DECEL_START_Q8:   csr_prdata = CSR_DATA_BITS'(decel_start_q8_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // datapath and control
   state_type                state_ff, state_in;
   logic [MV_BITS-1:0]       ramp_ff, ramp_in;
   logic                     finished_ff, finished_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [MV_BITS-1:0]       want_ff, want_in;
   logic                     hit_ff, hit_in;
   logic [OUT_BITS-1:0]      res_left_ff, res_left_in;
   logic [OUT_BITS-1:0]      res_right_ff, res_right_in;
   logic                     res_done_ff, res_done_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]      rsp_left_ff, rsp_left_in;
   logic [OUT_BITS-1:0]      rsp_right_ff, rsp_right_in;
   logic                     rsp_done_ff, rsp_done_in;

   logic                     req_accept;
   logic [POSITION_BITS-1:0] pos_sel;
   logic [POSITION_BITS-1:0] pos_mag;
   logic [Q8_BITS-1:0]       q_sat;
   logic [Q8_BITS-1:0]       q_rest;
   logic [DEC_BITS-1:0]      decel_lhs;
   logic [DEC_BITS-1:0]      decel_rhs;
   logic                     decel;
   logic [DEN_BITS-1:0]      den;
   logic                     short_of_target;
   logic [TGT_BITS-1:0]      remaining;
   logic [PROD_BITS-1:0]     prod;
   logic                     hit;
   logic [MV_BITS:0]         ramp_sum;
   logic [MUL_BITS-1:0]      inner_prod;
   logic [MUL_BITS-FRAC_BITS-1:0] inner_full;
   logic [MV_BITS-1:0]       inner_mag;
   logic [OUT_BITS-1:0]      outer_v;
   logic [OUT_BITS-1:0]      inner_v;
   div_req_type              div_req;
   div_rsp_type              div_rsp;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && !reset;

   assign pos_sel = turn_left_ff ? req_ch.right_position : req_ch.left_position;
   assign pos_mag = pos_sel[POSITION_BITS-1] ? POSITION_BITS'(~pos_sel + 1'b1) : pos_sel;

   assign q_sat     = (decel_start_q8_ff > Q8_ONE) ? Q8_ONE : decel_start_q8_ff;
   assign q_rest    = Q8_BITS'(Q8_ONE - q_sat);
   assign decel_lhs = DEC_BITS'({pos_ff, FRAC_BITS'(0)});
   assign decel_rhs = DEC_BITS'(target_degrees_ff * q_sat);
   assign decel     = decel_lhs > decel_rhs;
   assign den       = DEN_BITS'(target_degrees_ff * q_rest);
   assign short_of_target = CMP_BITS'(pos_ff) < CMP_BITS'(target_degrees_ff);
   assign remaining = TGT_BITS'(target_degrees_ff - TGT_BITS'(pos_ff));
   assign prod      = PROD_BITS'(max_millivolts_ff * remaining);
   assign hit       = ((CMP_BITS + 1)'(pos_ff) + DONE_TOL) >=
                      (CMP_BITS + 1)'(target_degrees_ff);

   assign ramp_sum   = (MV_BITS + 1)'(ramp_ff) + (MV_BITS + 1)'(slew_step_ff);
   assign inner_prod = MUL_BITS'(ramp_ff * inner_ratio_q8_ff);
   assign inner_full = inner_prod[MUL_BITS-1:FRAC_BITS];
   assign inner_mag  = (inner_full > (MUL_BITS - FRAC_BITS)'(OUT_MAX)) ? OUT_MAX :
                       MV_BITS'(inner_full);
   assign outer_v = move_forward_ff ? {1'b0, ramp_ff} : OUT_BITS'(~{1'b0, ramp_ff} + 1'b1);
   assign inner_v = move_forward_ff ? {1'b0, inner_mag} :
                    OUT_BITS'(~{1'b0, inner_mag} + 1'b1);

   always_comb begin
      state_in     = state_ff;
      ramp_in      = ramp_ff;
      finished_in  = finished_ff;
      pos_in       = pos_ff;
      want_in      = want_ff;
      hit_in       = hit_ff;
      res_left_in  = res_left_ff;
      res_right_in = res_right_ff;
      res_done_in  = res_done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_done_in  = rsp_done_ff;
      div_req.start    = 1'b0;
      div_req.rem_init = DEN_BITS'(prod >> LOW_SHIFT);
      div_req.num_low  = QUOT_BITS'({prod, FRAC_BITS'(0)});
      div_req.den      = den;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               pos_in = pos_mag;
               if (req_ch.restart) begin
                  ramp_in     = '0;
                  finished_in = 1'b0;
               end
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            hit_in = hit;
            if (finished_ff) begin
               res_left_in  = '0;
               res_right_in = '0;
               res_done_in  = 1'b1;
               state_in     = ST_OUT;
            end else if (!decel) begin
               want_in  = max_millivolts_ff;
               state_in = ST_RAMP;
            end else if ((den == '0) || !short_of_target) begin
               want_in  = floor_millivolts_ff;
               state_in = ST_RAMP;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               want_in  = (div_rsp.quot < floor_millivolts_ff) ? floor_millivolts_ff :
                          div_rsp.quot;
               state_in = ST_RAMP;
            end
         end
         ST_RAMP: begin
            if (ramp_ff < want_ff) begin
               ramp_in = (ramp_sum > (MV_BITS + 1)'(want_ff)) ? want_ff : MV_BITS'(ramp_sum);
            end else begin
               ramp_in = want_ff;
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            res_left_in  = turn_left_ff ? inner_v : outer_v;
            res_right_in = turn_left_ff ? outer_v : inner_v;
            res_done_in  = hit_ff;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = res_left_ff;
               rsp_right_in = res_right_ff;
               rsp_done_in  = res_done_ff;
               finished_in  = res_done_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ramp_ff      <= '0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ramp_ff      <= ramp_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      want_ff      <= want_in;
      hit_ff       <= hit_in;
      res_left_ff  <= res_left_in;
      res_right_ff <= res_right_in;
      res_done_ff  <= res_done_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_done_ff  <= rsp_done_in;
   end

   sddvp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.left_millivolts  = rsp_left_ff;
   assign rsp_ch.right_millivolts = rsp_right_ff;
   assign rsp_ch.done_res         = rsp_done_ff;

   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_PREP)
      else $error("accepted request did not enter prep");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("divide finished outside the divide state");

   a_finished_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && finished_ff) |->
      (res_left_ff == '0 && res_right_ff == '0 && res_done_ff))
      else $error("finished move produced nonzero drive");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result loaded outside the output state");

endmodule
